// ===== hdl/cfs_pkg.sv =====
// shared types and constants of the compass frame sync decoder
package cfs_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int CFG_INDEX_W = 2;

    typedef logic [7:0] byte_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 2'd1;

    localparam byte_t HEADER_FIRST_RESET  = 8'hAA;
    localparam byte_t HEADER_SECOND_RESET = 8'h55;
    localparam byte_t STATUS_DATA_ERROR   = 8'hFF;

    typedef enum logic [1:0] {
        RESULT_VALID     = 2'd0,
        RESULT_CHECKSUM  = 2'd1,
        RESULT_STATUS_FF = 2'd2
    } frame_result_t;

    typedef struct packed {
        logic signed [15:0] true_pitch;
        logic        [15:0] true_yaw;
        logic signed [15:0] mag_pitch;
        logic        [15:0] mag_yaw;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] field_x;
        logic signed [15:0] field_y;
        logic signed [15:0] field_z;
        byte_t              status_byte;
        frame_result_t      frame_result;
    } cfs_result_t;

endpackage

// ===== hdl/cfs_cell.sv =====
// one byte cell of the sliding receive window
module cfs_cell
    import cfs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  shift_en,
    input  byte_t byte_in,
    output byte_t byte_out
);

    byte_t byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

// ===== hdl/cfs_eval.sv =====
// header match, checksum test and field extraction on the window
module cfs_eval
    import cfs_pkg::*;
(
    input  byte_t       win [FRAME_BYTES],
    input  byte_t       header_first,
    input  byte_t       header_second,
    output logic        frame_hit,
    output cfs_result_t result
);

    byte_t sum_a;
    byte_t sum_b;
    byte_t sum;

    // two short partial sums, wrapping modulo 256
    assign sum_a = win[2] + win[3] + win[4] + win[5];
    assign sum_b = win[6] + win[7] + win[8] + win[9];
    assign sum   = sum_a + sum_b + win[10];

    assign frame_hit = (win[0] == header_first) && (win[1] == header_second);

    always_comb begin
        result = '0;
        if (sum != win[11]) begin
            result.frame_result = RESULT_CHECKSUM;
        end else begin
            result.true_pitch   = {win[3],  win[4]};
            result.true_yaw     = {win[5],  win[6]};
            result.mag_pitch    = {win[7],  win[8]};
            result.mag_yaw      = {win[9],  win[10]};
            result.gyro_x       = {win[12], win[13]};
            result.gyro_y       = {win[14], win[15]};
            result.gyro_z       = {win[16], win[17]};
            result.field_x      = {win[18], win[19]};
            result.field_y      = {win[20], win[21]};
            result.field_z      = {win[22], win[23]};
            result.status_byte  = win[2];
            result.frame_result = (win[2] == STATUS_DATA_ERROR) ? RESULT_STATUS_FF
                                                                : RESULT_VALID;
        end
    end

endmodule

// ===== hdl/cfs_out_buf.sv =====
// output register with skid stage for decoded frames
module cfs_out_buf
    import cfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  cfs_result_t push_data,
    output logic        can_push,
    output logic        out_valid,
    input  logic        out_ready,
    output cfs_result_t out_data
);

    logic        out_valid_reg,  out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    cfs_result_t out_data_reg,   out_data_next;
    cfs_result_t skid_data_reg,  skid_data_next;
    logic        pop;

    assign pop = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next = skid_data_reg;
                if (push) begin
                    skid_data_next = push_data;
                end else begin
                    skid_valid_next = 1'b0;
                end
            end else if (push) begin
                out_data_next = push_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/compass_frame_sync_decode.sv =====
// top level of the compass frame sync decoder
// a frame result is registered in the output stage, or in the skid stage if it is held
// throughput: one byte per cycle; a result waiting on m_ready does not stall input
// until a second result is held in the skid stage
// reset: synchronous active-low aresetn zeroes the window, loads header 0xaa/0x55
// and empties the output stages
module compass_frame_sync_decode
    import cfs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    // received byte channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    // decoded frame channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [15:0]     m_true_pitch,
    output logic        [15:0]     m_true_yaw,
    output logic signed [15:0]     m_mag_pitch,
    output logic        [15:0]     m_mag_yaw,
    output logic signed [15:0]     m_gyro_x,
    output logic signed [15:0]     m_gyro_y,
    output logic signed [15:0]     m_gyro_z,
    output logic signed [15:0]     m_field_x,
    output logic signed [15:0]     m_field_y,
    output logic signed [15:0]     m_field_z,
    output logic        [7:0]      m_status_byte,
    output logic        [1:0]      m_frame_result
);

    // header registers
    byte_t header_first_reg;
    byte_t header_second_reg;

    // window cells: cell 0 holds the oldest byte
    byte_t cell_q   [FRAME_BYTES];
    byte_t win_next [FRAME_BYTES];

    logic        in_accept;
    logic        frame_hit;
    logic        can_push;
    cfs_result_t eval_result;
    cfs_result_t out_data;

    // configuration is always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                REG_HEADER_SECOND: header_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input is held off only when both output stages are full
    assign s_ready   = can_push;
    assign in_accept = s_valid && s_ready;

    // each cell takes its newer neighbour's byte on every accepted transaction
    genvar gi;
    generate
        for (gi = 0; gi < FRAME_BYTES; gi++) begin : g_cell
            byte_t cell_in;
            if (gi == FRAME_BYTES - 1) begin : g_newest
                assign cell_in = s_rx_byte;
            end else begin : g_inner
                assign cell_in = cell_q[gi+1];
            end
            cfs_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (in_accept),
                .byte_in  (cell_in),
                .byte_out (cell_q[gi])
            );
            // window as it stands after this shift
            assign win_next[gi] = cell_in;
        end
    endgenerate

    // decode is done on the shifted window, so the result is ready with the shift
    cfs_eval u_eval (
        .win           (win_next),
        .header_first  (header_first_reg),
        .header_second (header_second_reg),
        .frame_hit     (frame_hit),
        .result        (eval_result)
    );

    cfs_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept && frame_hit),
        .push_data (eval_result),
        .can_push  (can_push),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    // result fields out to their own ports
    assign m_true_pitch   = out_data.true_pitch;
    assign m_true_yaw     = out_data.true_yaw;
    assign m_mag_pitch    = out_data.mag_pitch;
    assign m_mag_yaw      = out_data.mag_yaw;
    assign m_gyro_x       = out_data.gyro_x;
    assign m_gyro_y       = out_data.gyro_y;
    assign m_gyro_z       = out_data.gyro_z;
    assign m_field_x      = out_data.field_x;
    assign m_field_y      = out_data.field_y;
    assign m_field_z      = out_data.field_z;
    assign m_status_byte  = out_data.status_byte;
    assign m_frame_result = out_data.frame_result;

endmodule

// ===== hdl/cfs_checker.sv =====
// port-level assertions for the compass frame sync decoder, with bind
module cfs_checker
    import cfs_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [7:0]             cfg_data,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [7:0]             s_rx_byte,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic signed [15:0]     m_true_pitch,
    input logic        [15:0]     m_true_yaw,
    input logic signed [15:0]     m_mag_pitch,
    input logic        [15:0]     m_mag_yaw,
    input logic signed [15:0]     m_gyro_x,
    input logic signed [15:0]     m_gyro_y,
    input logic signed [15:0]     m_gyro_z,
    input logic signed [15:0]     m_field_x,
    input logic signed [15:0]     m_field_y,
    input logic signed [15:0]     m_field_z,
    input logic        [7:0]      m_status_byte,
    input logic        [1:0]      m_frame_result
);

    // output stages are empty straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_result)
            && $stable(m_status_byte) && $stable(m_true_pitch) && $stable(m_field_z))
        else $error("stalled result changed");

    // checksum failure carries zeroed fields
    a_cksum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_result == RESULT_CHECKSUM |->
            m_status_byte == 8'd0 && m_true_pitch == 16'sd0 && m_true_yaw == 16'd0
            && m_gyro_x == 16'sd0 && m_field_z == 16'sd0)
        else $error("checksum failure with non-zero fields");

    // result code agrees with the status byte on good frames
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_result != RESULT_CHECKSUM |->
            (m_frame_result == RESULT_STATUS_FF) == (m_status_byte == STATUS_DATA_ERROR))
        else $error("result code does not match status byte");

    // no code beyond the defined ones
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_result != 2'd3)
        else $error("undefined result code");

endmodule

bind compass_frame_sync_decode cfs_checker u_cfs_checker (.*);
